// ----- rtl/core/krl_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package krl_pkg;

  localparam int KEY_W    = 64;
  localparam int TIME_W   = 32;
  localparam int STATUS_W = 2;
  localparam int SLOT_W   = 4;

  localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_LIMITED = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd2;

  localparam logic OP_CHECK   = 1'b0;
  localparam logic OP_TRIGGER = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } krl_state_t;

endpackage

`default_nettype wire

// ----- rtl/core/krl_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module krl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- rtl/core/krl_cmp.sv -----
`timescale 1ns / 1ps
`default_nettype none

// gt = (a + b > thr), sum kept at full width so it never wraps
module krl_cmp (
  input  wire logic [krl_pkg::TIME_W-1:0] a,
  input  wire logic [krl_pkg::TIME_W-1:0] b,
  input  wire logic [krl_pkg::TIME_W-1:0] thr,
  output logic                            gt
);

  import krl_pkg::*;

  logic [TIME_W:0] sum;

  always_comb begin
    sum = {1'b0, a} + {1'b0, b};
    gt  = sum > {1'b0, thr};
  end

endmodule

`default_nettype wire

// ----- rtl/core/key_rate_limit_table_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Key rate-limit table.
// Input channel (in_valid/in_ready) takes one word per request: operation
// (check or trigger), key tag, current time and minimum interval. Result
// channel (out_valid/out_ready) returns one word per request: status and slot.
// Each request walks all TABLE_ENTRIES slots once through the tag, last-use
// and interval memories, one slot per cycle; expired slots are freed in the
// same walk that looks for a match and the first free slot. One shared
// adder-comparator does the expiry test per slot and then the limit test.
// A new request is taken only in the idle state, which the block reenters
// after the result is loaded, so requests do not overlap: each one runs its
// walk over the memory read port and its final step before the next is taken.
// The result sits in an output register; the next request may be accepted
// while it waits, and that request holds in its final step until the
// receiver takes the pending word.
// Reset clears all slot valid bits and the output valid; no clearing pass.
module key_rate_limit_table_unit #(
  parameter int TABLE_ENTRIES = 16,
  parameter int TAG_BITS      = 64
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic                            in_operation,
  input  wire logic [krl_pkg::KEY_W-1:0]       in_key_tag,
  input  wire logic [krl_pkg::TIME_W-1:0]      in_now_seconds,
  input  wire logic [krl_pkg::TIME_W-1:0]      in_min_interval,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic      [krl_pkg::STATUS_W-1:0]    out_status,
  output logic      [krl_pkg::SLOT_W-1:0]      out_slot
);

  import krl_pkg::*;

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(TABLE_ENTRIES);

  krl_state_t state_r, state_nxt;

  logic [CNT_W-1:0]         cnt_r;
  logic                     eval_vld_r;
  logic [IDX_W-1:0]         eval_idx_r;
  logic [TABLE_ENTRIES-1:0] valid_r;

  logic                     op_r;
  logic [TAG_BITS-1:0]      tag_r;
  logic [TIME_W-1:0]        now_r;
  logic [TIME_W-1:0]        ivl_r;

  logic                     match_r;
  logic [IDX_W-1:0]         match_idx_r;
  logic [TIME_W-1:0]        match_last_r;
  logic                     free_r;
  logic [IDX_W-1:0]         free_idx_r;

  logic                     out_valid_r;
  logic [STATUS_W-1:0]      out_status_r;
  logic [SLOT_W-1:0]        out_slot_r;

  // memory ports
  logic [TAG_BITS-1:0]      rd_tag;
  logic [TIME_W-1:0]        rd_last;
  logic [TIME_W-1:0]        rd_ivl;
  logic [IDX_W-1:0]         rd_addr;
  logic [IDX_W-1:0]         wr_addr;
  logic                     we_alloc;
  logic                     we_last;

  // shared compare unit
  logic [TIME_W-1:0]        cmp_a;
  logic [TIME_W-1:0]        cmp_b;
  logic                     cmp_gt;

  logic                     in_acc;
  logic                     scan_rd;
  logic                     load;
  logic                     ent_keep;
  logic                     ent_hit;
  logic [STATUS_W-1:0]      status_nxt;
  logic [IDX_W-1:0]         win_idx;
  logic                     win_any;
  logic [IDX_W+SLOT_W-1:0]  slot_ext;
  logic [SLOT_W-1:0]        slot_nxt;

  krl_ram #(.WIDTH(TAG_BITS), .DEPTH(TABLE_ENTRIES), .AW(IDX_W)) u_tag_ram (
    .clk   (clk),
    .we    (we_alloc),
    .waddr (wr_addr),
    .wdata (tag_r),
    .raddr (rd_addr),
    .rdata (rd_tag)
  );

  krl_ram #(.WIDTH(TIME_W), .DEPTH(TABLE_ENTRIES), .AW(IDX_W)) u_last_ram (
    .clk   (clk),
    .we    (we_last),
    .waddr (wr_addr),
    .wdata (now_r),
    .raddr (rd_addr),
    .rdata (rd_last)
  );

  krl_ram #(.WIDTH(TIME_W), .DEPTH(TABLE_ENTRIES), .AW(IDX_W)) u_ivl_ram (
    .clk   (clk),
    .we    (we_alloc),
    .waddr (wr_addr),
    .wdata (ivl_r),
    .raddr (rd_addr),
    .rdata (rd_ivl)
  );

  krl_cmp u_cmp (
    .a   (cmp_a),
    .b   (cmp_b),
    .thr (now_r),
    .gt  (cmp_gt)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (cnt_r == CNT_LAST) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_ready = 1'b0;
    scan_rd  = 1'b0;
    load     = 1'b0;
    cmp_a    = rd_last;
    cmp_b    = rd_ivl;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
      end
      ST_SCAN: begin
        scan_rd = (cnt_r != CNT_LAST);
      end
      ST_FINISH: begin
        load  = !out_valid_r || out_ready;
        cmp_a = match_last_r;
        cmp_b = ivl_r;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  assign in_acc  = in_valid && in_ready;
  assign rd_addr = cnt_r[IDX_W-1:0];

  // slot under evaluation: kept if last use + its interval is still ahead of now
  assign ent_keep = valid_r[eval_idx_r] && cmp_gt;
  assign ent_hit  = ent_keep && (rd_tag == tag_r);

  // final decision
  always_comb begin
    status_nxt = STATUS_OK;
    win_idx    = match_idx_r;
    win_any    = match_r;
    we_alloc   = 1'b0;
    we_last    = 1'b0;
    if (op_r == OP_TRIGGER) begin
      if (match_r) begin
        we_last = load;
      end else if (free_r) begin
        win_idx  = free_idx_r;
        win_any  = 1'b1;
        we_alloc = load;
        we_last  = load;
      end else begin
        status_nxt = STATUS_FULL;
      end
    end else if (match_r && cmp_gt) begin
      status_nxt = STATUS_LIMITED;
    end
    wr_addr  = win_idx;
    slot_ext = {{SLOT_W{1'b0}}, win_idx};
    slot_nxt = win_any ? slot_ext[SLOT_W-1:0] : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      eval_vld_r  <= 1'b0;
      valid_r     <= '0;
      match_r     <= 1'b0;
      free_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      eval_vld_r <= scan_rd;
      if (in_acc) begin
        cnt_r   <= '0;
        match_r <= 1'b0;
        free_r  <= 1'b0;
      end else if (scan_rd) begin
        cnt_r <= cnt_r + 1'b1;
      end
      if (eval_vld_r) begin
        valid_r[eval_idx_r] <= ent_keep;
        if (!ent_keep && !free_r) begin
          free_r <= 1'b1;
        end
        if (ent_hit && !match_r) begin
          match_r <= 1'b1;
        end
      end
      if (we_alloc) begin
        valid_r[free_idx_r] <= 1'b1;
      end
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r  <= in_operation;
      tag_r <= in_key_tag[TAG_BITS-1:0];
      now_r <= in_now_seconds;
      ivl_r <= in_min_interval;
    end
    eval_idx_r <= rd_addr;
    if (eval_vld_r) begin
      if (!ent_keep && !free_r) begin
        free_idx_r <= eval_idx_r;
      end
      if (ent_hit && !match_r) begin
        match_idx_r  <= eval_idx_r;
        match_last_r <= rd_last;
      end
    end
    if (load) begin
      out_status_r <= status_nxt;
      out_slot_r   <= slot_nxt;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_slot   = out_slot_r;

`ifndef ASSERT_OFF
  a_full_only_when_all_valid: assert property (
    @(posedge clk) disable iff (!rst_n)
    (load && status_nxt == STATUS_FULL) |-> (&valid_r)
  ) else $error("table full reported with a free slot");

  a_eval_only_in_scan: assert property (
    @(posedge clk) disable iff (!rst_n)
    eval_vld_r |-> (state_r == ST_SCAN)
  ) else $error("slot evaluated outside the table walk");

  a_scan_ends: assert property (
    @(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN && cnt_r == CNT_LAST) |=> (state_r == ST_FINISH)
  ) else $error("table walk did not finish");

  a_no_load_over_pending: assert property (
    @(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !load
  ) else $error("result overwritten before it was taken");
`endif

endmodule

`default_nettype wire
